// ----- rtl/spherical_texture_coord_assert.svh -----
// Assertion macros for the spherical texture coordinate block.
// Included by the top module, which checks its own pipeline; expects clk and rst_n in scope.
`ifndef SPHERICAL_TEXTURE_COORD_ASSERT_SVH
`define SPHERICAL_TEXTURE_COORD_ASSERT_SVH
`ifndef SYNTHESIS
`define STC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STC_ASSERT_IMPLY(label, ante, cons, msg)
`define STC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/stc_pkg.sv -----
// Shared types, constants and a helper function for the spherical texture coordinate block.
// No dependencies; imported by every module of the block.
package stc_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;

  // exact difference, then guard bits, then headroom for CORDIC gain
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int DP_W   = DIFF_W + GUARD_BITS + 3;
  // angle in 2^-32 turn, with room past a half turn
  localparam int ANG_W  = 35;

  // magnitude split for the gain correction product
  localparam int MAG_W = (DP_W - 1 > 32) ? DP_W - 1 : 33;
  localparam int HI_W  = MAG_W - 32;
  localparam int SUM_W = HI_W + 33;

  localparam int ATAN_IDX_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int TEX_W      = 16;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam logic signed [ANG_W-1:0] TURN_QUARTER = ANG_W'(64'd1 << 30);
  localparam logic signed [ANG_W:0]   TURN_HALF    = (ANG_W + 1)'(64'd1 << 31);

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2
  } stc_reg_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;
  } stc_in_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } stc_out_t;

  // one vector in flight through a CORDIC row; side rides along untouched
  typedef struct packed {
    logic                    zero;
    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
    logic signed [DP_W-1:0]  side;
  } stc_vec_t;

  // round a Q0.32 fraction to Q0.16, clamp below zero, saturate at one
  function automatic logic [TEX_W-1:0] to_q16(input logic signed [ANG_W:0] a);
    logic [ANG_W:0] r;
    r = (ANG_W + 1)'(0);
    if (a < 0) begin
      return '0;
    end
    r = (unsigned'(a) + (ANG_W + 1)'(32'h8000)) >> 16;
    if (r > (ANG_W + 1)'(32'hFFFF)) begin
      return '1;
    end
    return r[TEX_W-1:0];
  endfunction

endpackage

// ----- rtl/stc_prerot.sv -----
// Quadrant fold ahead of a CORDIC row: turns a vector with negative x by a quarter turn.
// Depends on stc_pkg.
module stc_prerot (
  input  logic signed [stc_pkg::DP_W-1:0] x,
  input  logic signed [stc_pkg::DP_W-1:0] y,
  input  logic signed [stc_pkg::DP_W-1:0] side,
  output stc_pkg::stc_vec_t               vec
);
  import stc_pkg::*;

  always_comb begin
    vec      = '0;
    vec.zero = (x == '0) && (y == '0);
    vec.side = side;
    if (x < 0) begin
      if (y >= 0) begin
        vec.x   = y;
        vec.y   = -x;
        vec.ang = TURN_QUARTER;
      end else begin
        vec.x   = -y;
        vec.y   = x;
        vec.ang = -TURN_QUARTER;
      end
    end else begin
      vec.x   = x;
      vec.y   = y;
      vec.ang = '0;
    end
  end

endmodule

// ----- rtl/stc_cell.sv -----
// One CORDIC vectoring step with its output register; step index selects shift and angle.
// Depends on stc_pkg.
module stc_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [stc_pkg::ATAN_IDX_W-1:0]   step,
  input  logic                             in_valid,
  input  stc_pkg::stc_vec_t                in_vec,
  output logic                             out_valid,
  output stc_pkg::stc_vec_t                out_vec
);
  import stc_pkg::*;

  logic signed [DP_W-1:0]  x_in;
  logic signed [DP_W-1:0]  y_in;
  logic signed [DP_W-1:0]  xs;
  logic signed [DP_W-1:0]  ys;
  logic signed [ANG_W-1:0] at;
  stc_vec_t                vec_nxt;
  stc_vec_t                vec_r;
  logic                    valid_r;

  always_comb begin
    x_in    = in_vec.x;
    y_in    = in_vec.y;
    xs      = x_in >>> step;
    ys      = y_in >>> step;
    at      = ANG_W'(ATAN_TURNS[step]);
    vec_nxt = in_vec;
    // rotate toward y = 0
    if (y_in >= 0) begin
      vec_nxt.x   = x_in + ys;
      vec_nxt.y   = y_in - xs;
      vec_nxt.ang = in_vec.ang + at;
    end else begin
      vec_nxt.x   = x_in - ys;
      vec_nxt.y   = y_in + xs;
      vec_nxt.ang = in_vec.ang - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ----- rtl/stc_chain.sv -----
// Row of CORDIC_STEPS cells, each handing its vector to the next every enabled cycle.
// Depends on stc_pkg and stc_cell.
module stc_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  stc_pkg::stc_vec_t in_vec,
  output logic              out_valid,
  output stc_pkg::stc_vec_t out_vec
);
  import stc_pkg::*;

  logic     valid_tap [CORDIC_STEPS+1];
  stc_vec_t vec_tap   [CORDIC_STEPS+1];

  assign valid_tap[0] = in_valid;
  assign vec_tap[0]   = in_vec;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    stc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .step      (ATAN_IDX_W'(i)),
      .in_valid  (valid_tap[i]),
      .in_vec    (vec_tap[i]),
      .out_valid (valid_tap[i+1]),
      .out_vec   (vec_tap[i+1])
    );
  end

  assign out_valid = valid_tap[CORDIC_STEPS];
  assign out_vec   = vec_tap[CORDIC_STEPS];

endmodule

// ----- rtl/spherical_texture_coord.sv -----
// Top level of the spherical texture coordinate block: origin registers and the full pipeline.
// Depends on stc_pkg, stc_prerot, stc_chain and spherical_texture_coord_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one vertex request in signed
//   Q16.16; output channel (out_valid / out_stall / out_data) returns tex_u and tex_v in
//   unsigned Q0.16. Write origin_x/y/z through cfg_we / cfg_index / cfg_data while idle.
//   Pipeline: difference, quadrant fold, CORDIC_STEPS azimuth cells, gain product, gain
//   sum, quadrant fold, CORDIC_STEPS polar cells, output register.
//   Depth: 2 * CORDIC_STEPS + 6 register stages (38 at 16 steps); the last of them is the
//   output register that drives out_valid and out_data.
//   Throughput: one request per clock while the pipe is not stalled; each CORDIC row is a
//   chain of registered cells, one step per cell, so a new vertex can enter every cycle.
//   Stall: the whole pipe advances together. When out_data is held and out_stall is
//   high, every stage freezes and in_stall rises in the same cycle; a free output slot
//   lets the pipe move on, and a request is taken in the same cycle the result leaves.
//   Reset (rst_n low, synchronous): clears all stage valids and out_valid, sets the
//   origins to zero, and holds in_stall high so nothing is taken.
`include "spherical_texture_coord_assert.svh"
module spherical_texture_coord (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stc_pkg::stc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output stc_pkg::stc_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stc_pkg::COORD_WIDTH-1:0]   cfg_data
);
  import stc_pkg::*;

  // configuration
  coord_t origin_x_r;
  coord_t origin_y_r;
  coord_t origin_z_r;

  // pipeline enable: advance whenever the output slot is free or being drained
  logic en;
  logic accept;

  // difference stage
  logic                   d_valid_r;
  logic signed [DP_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DP_W-1:0] dx_r, dy_r, dz_r;

  // first fold and azimuth row
  stc_vec_t p1_vec_nxt;
  stc_vec_t p1_vec_r;
  logic     p1_valid_r;
  stc_vec_t c1_vec;
  logic     c1_valid;

  // gain product stage
  logic                    m_valid_r;
  logic [MAG_W-1:0]        mag;
  logic signed [ANG_W-1:0] theta_nxt;
  logic [HI_W+31:0]        p_hi_nxt, p_hi_r;
  logic [63:0]             p_lo_nxt, p_lo_r;
  logic signed [ANG_W-1:0] m_theta_r;
  logic signed [DP_W-1:0]  m_dy_r;

  // gain sum stage
  logic                    r_valid_r;
  logic [SUM_W-1:0]        r_sum;
  logic signed [DP_W-1:0]  r_nxt, r_r;
  logic signed [ANG_W-1:0] r_theta_r;
  logic signed [DP_W-1:0]  r_dy_r;

  // second fold and polar row
  stc_vec_t p2_vec_nxt;
  stc_vec_t p2_vec_r;
  logic     p2_valid_r;
  stc_vec_t c2_vec;
  logic     c2_valid;

  // output
  logic signed [ANG_W-1:0] phi;
  logic signed [ANG_W-1:0] theta_out;
  stc_out_t                out_data_nxt;
  stc_out_t                out_data_r;
  logic                    out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || !en;
  assign accept   = in_valid && !in_stall;

  // origin registers; unknown index drops the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        REG_ORIGIN_Z: origin_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // exact differences at DIFF_W bits, then scaled by the guard bits
  always_comb begin
    logic signed [DIFF_W-1:0] ddx, ddy, ddz;
    ddx = {in_data.vertex_x[COORD_WIDTH-1], in_data.vertex_x}
        - {origin_x_r[COORD_WIDTH-1], origin_x_r};
    ddy = {in_data.vertex_y[COORD_WIDTH-1], in_data.vertex_y}
        - {origin_y_r[COORD_WIDTH-1], origin_y_r};
    ddz = {in_data.vertex_z[COORD_WIDTH-1], in_data.vertex_z}
        - {origin_z_r[COORD_WIDTH-1], origin_z_r};
    dx_nxt = {{(DP_W-DIFF_W){ddx[DIFF_W-1]}}, ddx} <<< GUARD_BITS;
    dy_nxt = {{(DP_W-DIFF_W){ddy[DIFF_W-1]}}, ddy} <<< GUARD_BITS;
    dz_nxt = {{(DP_W-DIFF_W){ddz[DIFF_W-1]}}, ddz} <<< GUARD_BITS;
  end

  // azimuth vector (dx, dz); dy rides along as side data
  stc_prerot u_prerot_az (
    .x    (dx_r),
    .y    (dz_r),
    .side (dy_r),
    .vec  (p1_vec_nxt)
  );

  stc_chain u_chain_az (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_valid_r),
    .in_vec    (p1_vec_r),
    .out_valid (c1_valid),
    .out_vec   (c1_vec)
  );

  // azimuth is zero for a null vector; negative magnitude clamps to zero.
  // Split the 1/K product into a high and a low partial product.
  always_comb begin
    theta_nxt = c1_vec.zero ? '0 : c1_vec.ang;
    mag       = c1_vec.x[DP_W-1] ? '0 : MAG_W'(unsigned'(c1_vec.x[DP_W-2:0]));
    p_hi_nxt  = (HI_W + 32)'(mag[MAG_W-1:32]) * (HI_W + 32)'(INV_GAIN);
    p_lo_nxt  = 64'(mag[31:0]) * 64'(INV_GAIN);
  end

  // radial magnitude, truncated
  always_comb begin
    r_sum = SUM_W'(p_hi_r) + SUM_W'(p_lo_r[63:32]);
    r_nxt = DP_W'(r_sum);
  end

  // polar vector (dy, radius); azimuth rides along as side data
  stc_prerot u_prerot_pol (
    .x    (r_dy_r),
    .y    (r_r),
    .side (DP_W'(r_theta_r)),
    .vec  (p2_vec_nxt)
  );

  stc_chain u_chain_pol (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_valid_r),
    .in_vec    (p2_vec_r),
    .out_valid (c2_valid),
    .out_vec   (c2_vec)
  );

  // map azimuth from (-half, half] turn and polar angle from [0, half] turn onto [0, 1]
  always_comb begin
    phi                = c2_vec.zero ? '0 : c2_vec.ang;
    theta_out          = c2_vec.side[ANG_W-1:0];
    out_data_nxt.tex_u = to_q16((ANG_W + 1)'(theta_out) + TURN_HALF);
    out_data_nxt.tex_v = to_q16((ANG_W + 1)'(phi) <<< 1);
  end

  // stage valids advance together; hold everything while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      p1_valid_r  <= 1'b0;
      m_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r   <= accept;
      p1_valid_r  <= d_valid_r;
      m_valid_r   <= c1_valid;
      r_valid_r   <= m_valid_r;
      p2_valid_r  <= r_valid_r;
      out_valid_r <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      dz_r       <= dz_nxt;
      p1_vec_r   <= p1_vec_nxt;
      p_hi_r     <= p_hi_nxt;
      p_lo_r     <= p_lo_nxt;
      m_theta_r  <= theta_nxt;
      m_dy_r     <= c1_vec.side;
      r_r        <= r_nxt;
      r_theta_r  <= m_theta_r;
      r_dy_r     <= m_dy_r;
      p2_vec_r   <= p2_vec_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STC_ASSERT_NEXT(a_accept_enters, accept, d_valid_r, "accepted request did not enter the pipe")
  `STC_ASSERT_IMPLY(a_null_mag, c1_valid && c1_vec.zero, c1_vec.x == '0, "null vector grew a magnitude")
  `STC_ASSERT_IMPLY(a_radius_sign, r_valid_r, !r_r[DP_W-1], "radius came out negative")

endmodule
